// ===== hw/rtl/sida_pkg.sv =====
package sida_pkg;

  // Sizes of the conversion
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned DD_STAGES = 4;
  localparam int unsigned DD_BITS  = BIN_W / DD_STAGES;

  // Character codes, 6 bits wide
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // Payload carried between pipeline stages
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } stage_t;

  // Shift-and-add-3 over DD_BITS input bits
  function automatic logic [BCD_W+BIN_W-1:0] dd_steps(input logic [BCD_W+BIN_W-1:0] x);
    logic [BCD_W+BIN_W-1:0] v;
    v = x;
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (v[BIN_W+4*d +: 4] >= 4'd5) begin
          v[BIN_W+4*d +: 4] = v[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      v = v << 1;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII, one character per output transaction.
// Pipeline: sign stage, binary-to-BCD dabble stages, then the character serializer.
// Throughput: one character per output transaction (1 to 11 per number), set by the
//   output port; the conversion pipeline takes one input per cycle unless stalled.
// Reset: synchronous active-high rst clears all valid flags; nothing is in flight after.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] text_char, [7:6] zero
  output logic        m_axis_tlast
);

  localparam int unsigned N = sida_pkg::DD_STAGES;

  logic             vld [0:N];
  logic             rdy [0:N];
  sida_pkg::stage_t st  [0:N];
  logic [5:0]       text_char;

  // sign and magnitude
  sida_sign u_sign (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_axis_tvalid),
    .in_value (s_axis_tdata),
    .in_rdy   (s_axis_tready),
    .out_vld  (vld[0]),
    .out_data (st[0]),
    .out_rdy  (rdy[0])
  );

  // binary-to-BCD pipeline
  for (genvar g = 0; g < N; g++) begin : g_dd
    sida_dabble u_dd (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld[g]),
      .in_data  (st[g]),
      .in_rdy   (rdy[g]),
      .out_vld  (vld[g+1]),
      .out_data (st[g+1]),
      .out_rdy  (rdy[g+1])
    );
  end

  // character serializer
  sida_serial u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld[N]),
    .in_data  (st[N]),
    .in_rdy   (rdy[N]),
    .out_vld  (m_axis_tvalid),
    .out_char (text_char),
    .out_last (m_axis_tlast),
    .out_rdy  (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, text_char};

endmodule

// ===== hw/rtl/sida_sign.sv =====
module sida_sign (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [31:0]         in_value,
  output logic                in_rdy,
  output logic                out_vld,
  output sida_pkg::stage_t    out_data,
  input  logic                out_rdy
);

  logic             vld;
  sida_pkg::stage_t data;

  assign in_rdy   = !vld || out_rdy;
  assign out_vld  = vld;
  assign out_data = data;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= in_vld;
    end
  end

  // sign and unsigned magnitude
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data.neg <= in_value[31];
      data.bcd <= '0;
      data.bin <= in_value[31] ? (32'd0 - in_value) : in_value;
    end
  end

endmodule

// ===== hw/rtl/sida_dabble.sv =====
module sida_dabble (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  sida_pkg::stage_t    in_data,
  output logic                in_rdy,
  output logic                out_vld,
  output sida_pkg::stage_t    out_data,
  input  logic                out_rdy
);

  logic             vld;
  sida_pkg::stage_t data;
  logic [sida_pkg::BCD_W+sida_pkg::BIN_W-1:0] stepped;

  assign in_rdy   = !vld || out_rdy;
  assign out_vld  = vld;
  assign out_data = data;

  // one slice of the binary-to-BCD conversion
  assign stepped = sida_pkg::dd_steps({in_data.bcd, in_data.bin});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data.neg <= in_data.neg;
      data.bcd <= stepped[sida_pkg::BIN_W +: sida_pkg::BCD_W];
      data.bin <= stepped[sida_pkg::BIN_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/sida_serial.sv =====
module sida_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  sida_pkg::stage_t    in_data,
  output logic                in_rdy,
  output logic                out_vld,
  output logic [5:0]          out_char,
  output logic                out_last,
  input  logic                out_rdy
);

  logic                       busy;
  logic                       neg_pend;
  logic [sida_pkg::BCD_W-1:0] digs;
  logic [3:0]                 rem;
  logic                       vld;
  logic [5:0]                 chr;
  logic                       lst;

  logic                       emit;
  logic                       final_dig;
  logic                       load;
  logic [3:0]                 lead;
  logic [sida_pkg::BCD_W-1:0] aligned;

  assign out_vld  = vld;
  assign out_char = chr;
  assign out_last = lst;

  assign emit      = busy && (!vld || out_rdy);
  assign final_dig = !neg_pend && (rem == 4'd1);
  assign in_rdy    = !busy || (emit && final_dig);
  assign load      = in_vld && in_rdy;

  // highest nonzero digit, zero gives digit 0
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < sida_pkg::DIGITS; i++) begin
      if (in_data.bcd[4*i +: 4] != 4'd0) begin
        lead = 4'(i);
      end
    end
  end

  // leading digit moved to the top nibble
  assign aligned = in_data.bcd << {(4'(sida_pkg::DIGITS - 1) - lead), 2'b00};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      vld      <= 1'b0;
      neg_pend <= 1'b0;
    end else begin
      if (!vld || out_rdy) begin
        vld <= busy;
      end
      if (load) begin
        busy     <= 1'b1;
        neg_pend <= in_data.neg;
      end else if (emit) begin
        if (final_dig) begin
          busy <= 1'b0;
        end
        neg_pend <= 1'b0;
      end
    end
  end

  // character output and digit shifter
  always_ff @(posedge clk) begin
    if (emit) begin
      if (neg_pend) begin
        chr <= sida_pkg::CHAR_MINUS;
        lst <= 1'b0;
      end else begin
        chr  <= sida_pkg::CHAR_ZERO + {2'b00, digs[sida_pkg::BCD_W-1 -: 4]};
        lst  <= (rem == 4'd1);
        digs <= digs << 4;
        rem  <= rem - 4'd1;
      end
    end
    if (load) begin
      digs <= aligned;
      rem  <= lead + 4'd1;
    end
  end

endmodule

// ===== hw/rtl/sida_checker.sv =====
module sida_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // only minus or digits appear
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == 8'd45) ||
      ((m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57)))
    else $error("bad character code");

  // a minus sign is never the end of a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata == 8'd45) |-> !m_axis_tlast)
    else $error("minus flagged last");

  // after a delivered minus, the next digit is not a leading zero
  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == 8'd45) |=>
      !(m_axis_tvalid && (m_axis_tdata == 8'd48)))
    else $error("leading zero after minus");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
